>>> rtl/pvd_pkg.sv
// Types and constants shared by the prefix-length varint decoder.
package pvd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] target_size;
    logic       target_is_signed;
    logic       encoding_is_signed;
  } pvd_in_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } pvd_out_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NEG_UNSIGNED = 2'd1,
    ST_TOO_BIG      = 2'd2,
    ST_RESERVED     = 2'd3
  } pvd_status_t;

  localparam int          LONG_MIN_BYTES = 4;
  localparam logic [3:0]  EXCESS_MAX     = 4'hF;

endpackage

>>> rtl/prefix_length_varint_decoder.sv
// Prefix-length varint decoder: input register, one-pass decode, result register.
//
// Usage: one encoded byte per input transaction on in_data (with the target
// size and sign flags, which count only on a number's first byte). The first
// byte gives the length by its leading ones: 1 to 4 bytes (7 to 28 data bits)
// or a long form 1111nnnn followed by nnnn+4 data bytes, all big-endian.
// When a number completes, one result transaction carries the value in the
// target width (sign or zero extended to 64 bits) and a status: ok, negative
// into unsigned, too big, or reserved length. Bytes that do not complete a
// number give no result.
// Throughput: one byte per cycle unless a completing byte waits on a stalled
// result, set by the single decode pass between the input register and the
// result register, which is loaded as the number's last byte leaves the input.
// Reset: synchronous active-low rst_n drops both valid flags and returns the
// decoder to awaiting a first byte.
// Stall: a waiting result stays in the output register; bytes that give no
// result keep flowing, and a completing byte waits in the input register,
// which raises in_stall until out_stall drops.
module prefix_length_varint_decoder
  import pvd_pkg::*;
#(
  parameter int MAX_LONG_BYTES   = 16,
  parameter int MAX_TARGET_BYTES = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pvd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pvd_out_t out_data
);

  localparam int BLW = $clog2(MAX_LONG_BYTES + 1);
  localparam logic [BLW-1:0] LongMin  = BLW'(LONG_MIN_BYTES);
  localparam logic [4:0]     LongMax  = 5'(MAX_LONG_BYTES);
  localparam logic [3:0]     MaxTgtB  = 4'(MAX_TARGET_BYTES);

  pvd_in_t        s1_r;
  logic           s1_valid_r;
  logic [BLW-1:0] bytes_left_r, bytes_left_nxt;
  logic [63:0]    acc_r, acc_nxt;
  logic [3:0]     mode_r, mode_nxt;
  logic           fit_err_r, fit_err_nxt;
  logic [3:0]     excess_r, excess_nxt;
  pvd_out_t       out_r, res;
  logic           out_valid_r;
  logic           done;
  logic           s2_go;

  always_comb begin
    logic [7:0]  b;
    logic        esig, tsig, neg, fin;
    logic [4:0]  lsize;
    logic [3:0]  tb_raw, tb;
    logic [6:0]  nbits;
    logic [63:0] mask, hi, sbit, v;
    logic [1:0]  st;
    b              = s1_r.data_byte;
    bytes_left_nxt = bytes_left_r;
    acc_nxt        = acc_r;
    mode_nxt       = mode_r;
    fit_err_nxt    = fit_err_r;
    excess_nxt     = excess_r;
    done           = 1'b0;
    fin            = 1'b0;
    res.value      = '0;
    res.status     = ST_RESERVED;
    lsize          = {1'b0, b[3:0]} + 5'(LONG_MIN_BYTES);

    if (bytes_left_r == '0) begin
      mode_nxt    = {s1_r.encoding_is_signed, s1_r.target_is_signed, s1_r.target_size};
      fit_err_nxt = 1'b0;
      excess_nxt  = '0;
      esig        = s1_r.encoding_is_signed;
      case (b[7:4]) inside
        4'b0??? : begin
          acc_nxt = {{57{esig & b[6]}}, b[6:0]};
          fin     = 1'b1;
        end
        4'b10?? : begin
          acc_nxt        = {{58{esig & b[5]}}, b[5:0]};
          bytes_left_nxt = BLW'(1);
        end
        4'b110? : begin
          acc_nxt        = {{59{esig & b[4]}}, b[4:0]};
          bytes_left_nxt = BLW'(2);
        end
        4'b1110 : begin
          acc_nxt        = {{60{esig & b[3]}}, b[3:0]};
          bytes_left_nxt = BLW'(3);
        end
        default : begin
          acc_nxt = '0;
          if (lsize > LongMax) begin
            done = 1'b1;
          end else begin
            bytes_left_nxt = BLW'(lsize);
          end
        end
      endcase
    end else begin
      esig = mode_r[3];
      if (excess_r == '0 && bytes_left_r >= LongMin) begin
        acc_nxt    = {{56{esig & b[7]}}, b};
        excess_nxt = 4'd1;
      end else begin
        if (esig) begin
          if (acc_r[63:55] != '0 && acc_r[63:55] != '1) fit_err_nxt = 1'b1;
        end else if (acc_r[63:56] != '0) begin
          fit_err_nxt = 1'b1;
        end
        acc_nxt = {acc_r[55:0], b};
        if (excess_r != '0 && excess_r < EXCESS_MAX) excess_nxt = excess_r + 4'd1;
      end
      bytes_left_nxt = bytes_left_r - BLW'(1);
      fin            = (bytes_left_nxt == '0);
    end

    // completion: fit check and target-width extension
    tsig   = mode_nxt[2];
    neg    = mode_nxt[3] & acc_nxt[63];
    tb_raw = 4'd1 << mode_nxt[1:0];
    tb     = (tb_raw > MaxTgtB) ? MaxTgtB : tb_raw;
    nbits  = {tb, 3'b000};
    mask   = ~64'd0 >> (7'd64 - nbits);
    hi     = ~(mask >> 1);
    sbit   = mask & hi;
    if (fit_err_nxt) begin
      st = ST_TOO_BIG;
    end else if (neg && !tsig) begin
      st = ST_NEG_UNSIGNED;
    end else if (tsig) begin
      st = ((acc_nxt & hi) != (neg ? hi : 64'd0)) ? ST_TOO_BIG : ST_OK;
    end else begin
      st = ((acc_nxt & ~mask) != '0) ? ST_TOO_BIG : ST_OK;
    end
    v = acc_nxt & mask;
    if (tsig && ((acc_nxt & sbit) != '0)) v = v | ~mask;

    if (fin) begin
      done           = 1'b1;
      res.value      = v;
      res.status     = st;
      bytes_left_nxt = '0;
      fit_err_nxt    = 1'b0;
      excess_nxt     = '0;
    end
  end

  assign s2_go    = s1_valid_r && !(done && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s2_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      bytes_left_r <= '0;
      fit_err_r    <= 1'b0;
      excess_r     <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (s2_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_go) begin
        bytes_left_r <= bytes_left_nxt;
        fit_err_r    <= fit_err_nxt;
        excess_r     <= excess_nxt;
      end
      if (s2_go && done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_r <= in_data;
    if (s2_go) begin
      acc_r  <= acc_nxt;
      mode_r <= mode_nxt;
    end
    if (s2_go && done) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("in_stall raised with empty input register");

  a_reserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_RESERVED |-> out_r.value == '0)
    else $error("reserved length result carries a nonzero value");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r <= BLW'(MAX_LONG_BYTES))
    else $error("byte count beyond longest form");

  a_fit_long_only: assert property (@(posedge clk) disable iff (!rst_n)
    fit_err_r |-> excess_r != '0)
    else $error("fit error outside a long form");

endmodule
